### rtl/vemaroc_pkg.sv
// Shared types and constants for the volatility EMA rate-of-change block.
`timescale 1ns / 1ps
package vemaroc_pkg;
    localparam int E_W            = 49;
    localparam int SEED_W         = 44;
    localparam int ALPHA_W        = 24;
    localparam int MAX_EMA_PERIOD = 1024;

    localparam logic [0:0] REG_EMA_PERIOD = 1'b0;
    localparam logic [0:0] REG_ROC_PERIOD = 1'b1;

    typedef struct packed {
        logic signed [E_W-1:0] ema;
        logic signed [E_W-1:0] lag;
        logic [31:0]           idx;
        logic                  last;
    } vemaroc_job_t;
endpackage

### rtl/vemaroc_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vemaroc_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 11
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);
    localparam int CW = $clog2(NUM_W);

    logic [NUM_W-1:0] sh_reg;
    logic [DEN_W-1:0] rem_reg, den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             run_reg, done_reg;
    logic [DEN_W:0]   trial, sub;
    logic             ge;

    assign trial = {rem_reg, sh_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign sub   = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
            end else if (run_reg && cnt_reg == '0) begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
            cnt_reg <= CW'(NUM_W - 1);
        end else if (run_reg) begin
            rem_reg <= ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
            sh_reg  <= {sh_reg[NUM_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;
    assign rem  = rem_reg;
endmodule

### rtl/vemaroc_front.sv
// Front end: takes bars, runs the seed average, EMA update and lag ring.
`timescale 1ns / 1ps
module vemaroc_front import vemaroc_pkg::*; #(
    parameter int MAX_LAG = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  logic [10:0]  ema_period,
    input  logic [5:0]   roc_period,
    input  logic         ema_wr,
    output logic         job_valid,
    input  logic         job_ready,
    output vemaroc_job_t job
);
    localparam int PW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;

    localparam logic [2:0] ST_ALPHA = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_SEED  = 3'd3;
    localparam logic [2:0] ST_MULH  = 3'd4;
    localparam logic [2:0] ST_MULL  = 3'd5;
    localparam logic [2:0] ST_PUSH  = 3'd6;

    localparam logic signed [E_W-1:0] E_MAX = {1'b0, {(E_W-1){1'b1}}};
    localparam logic signed [E_W-1:0] E_MIN = {1'b1, {(E_W-1){1'b0}}};

    logic [2:0]               state_reg;
    logic                     start_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic signed [E_W-1:0]    ema_reg;
    logic signed [SEED_W-1:0] seed_reg;
    logic [31:0]              bars_reg;
    logic [PW-1:0]            ptr_reg;
    logic signed [32:0]       spread_reg;
    logic                     last_reg, emit_reg, neg_reg;
    logic [49:0]              mag_reg;
    logic [49:0]              acc_reg;
    logic signed [E_W-1:0]    lag_reg;
    logic signed [E_W-1:0]    ring_mem [MAX_LAG];

    logic [10:0]              p_eff, d_eff;
    logic [5:0]               r_eff;
    logic [31:0]              p_m1, emit_at;
    logic signed [SEED_W-1:0] seed_new;
    logic [SEED_W-1:0]        seed_abs;
    logic [59:0]              div_num, div_quo;
    logic [10:0]              div_den, div_rem;
    logic                     div_done;
    logic signed [49:0]       diff;
    logic [49:0]              diff_mag, mul_out;
    logic [25:0]              mul_a;
    logic [49:0]              step;
    logic signed [52:0]       e_sum;
    logic signed [E_W-1:0]    e_upd, e_seed;
    logic [PW-1:0]            ptr_next;
    logic                     push_go;

    always_comb begin
        if (ema_period < 11'd2) p_eff = 11'd2;
        else if (int'(ema_period) > MAX_EMA_PERIOD) p_eff = 11'(MAX_EMA_PERIOD);
        else p_eff = ema_period;
        if (roc_period == 6'd0) r_eff = 6'd1;
        else if (int'(roc_period) > MAX_LAG) r_eff = 6'(MAX_LAG);
        else r_eff = roc_period;
    end

    assign d_eff   = p_eff + 11'd1;
    assign p_m1    = {21'b0, p_eff} - 32'd1;
    assign emit_at = p_m1 + {26'b0, r_eff};

    assign seed_new = seed_reg + SEED_W'(spread_reg);
    assign seed_abs = seed_reg[SEED_W-1] ? SEED_W'(-seed_reg) : SEED_W'(seed_reg);
    assign div_num  = (state_reg == ST_ALPHA)
                    ? (60'd1 << 25) + {50'b0, d_eff[10:1]}
                    : {seed_abs, 16'b0} + {50'b0, p_eff[10:1]};
    assign div_den  = (state_reg == ST_ALPHA) ? d_eff : p_eff;

    vemaroc_div #(.NUM_W(60), .DEN_W(11)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    always_comb begin
        if (!seed_reg[SEED_W-1])
            e_seed = (div_quo > 60'(E_MAX)) ? E_MAX : E_W'(div_quo);
        else
            e_seed = (div_quo > (60'd1 << (E_W-1))) ? E_MIN : E_W'(-div_quo);
    end

    assign diff     = (50'(spread_reg) <<< 16) - 50'(ema_reg);
    assign diff_mag = diff[49] ? 50'(-diff) : 50'(diff);

    assign mul_a   = (state_reg == ST_MULH) ? mag_reg[49:24] : {2'b0, mag_reg[23:0]};
    assign mul_out = 50'(mul_a * alpha_reg);
    assign step    = acc_reg + 50'((mul_out + 50'(1 << 23)) >> 24);
    assign e_sum   = neg_reg ? 53'(ema_reg) - 53'(step) : 53'(ema_reg) + 53'(step);

    always_comb begin
        if (e_sum > 53'(E_MAX)) e_upd = E_MAX;
        else if (e_sum < 53'(E_MIN)) e_upd = E_MIN;
        else e_upd = E_W'(e_sum);
    end

    assign ptr_next = ((32'(ptr_reg) + 32'd1) >= 32'(r_eff)) ? '0 : ptr_reg + 1'b1;
    assign push_go  = (state_reg == ST_PUSH) && (!emit_reg || job_ready);

    assign s_tready  = (state_reg == ST_IDLE) && !ema_wr;
    assign job_valid = (state_reg == ST_PUSH) && emit_reg;
    assign job.ema   = ema_reg;
    assign job.lag   = lag_reg;
    assign job.idx   = bars_reg;
    assign job.last  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ALPHA;
            start_reg <= 1'b1;
            ema_reg   <= '0;
            seed_reg  <= '0;
            bars_reg  <= '0;
            ptr_reg   <= '0;
            emit_reg  <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (ema_wr) begin
                state_reg <= ST_ALPHA;
                start_reg <= 1'b1;
            end else begin
                unique case (state_reg)
                    ST_ALPHA: begin
                        if (div_done && !start_reg) begin
                            alpha_reg <= div_quo[ALPHA_W-1:0];
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (s_tvalid) begin
                            spread_reg <= $signed({1'b0, s_tdata[31:0]})
                                        - $signed({1'b0, s_tdata[63:32]});
                            last_reg   <= s_tlast;
                            if (s_tuser) begin
                                ema_reg  <= '0;
                                seed_reg <= '0;
                                bars_reg <= '0;
                                ptr_reg  <= '0;
                            end
                            state_reg <= ST_EVAL;
                        end
                    end
                    ST_EVAL: begin
                        lag_reg <= ring_mem[ptr_reg];
                        if (bars_reg < p_m1) begin
                            seed_reg  <= seed_new;
                            bars_reg  <= bars_reg + 32'd1;
                            state_reg <= ST_IDLE;
                        end else if (bars_reg == p_m1) begin
                            seed_reg  <= seed_new;
                            start_reg <= 1'b1;
                            emit_reg  <= 1'b0;
                            state_reg <= ST_SEED;
                        end else begin
                            mag_reg   <= diff_mag;
                            neg_reg   <= diff[49];
                            emit_reg  <= bars_reg >= emit_at;
                            state_reg <= ST_MULH;
                        end
                    end
                    ST_SEED: begin
                        if (div_done && !start_reg) begin
                            ema_reg   <= e_seed;
                            state_reg <= ST_PUSH;
                        end
                    end
                    ST_MULH: begin
                        acc_reg   <= mul_out;
                        state_reg <= ST_MULL;
                    end
                    ST_MULL: begin
                        ema_reg   <= e_upd;
                        state_reg <= ST_PUSH;
                    end
                    ST_PUSH: begin
                        if (push_go) begin
                            ptr_reg   <= ptr_next;
                            if (bars_reg != 32'hFFFF_FFFF) bars_reg <= bars_reg + 32'd1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_go) ring_mem[ptr_reg] <= ema_reg;
    end
endmodule

### rtl/vemaroc_fifo.sv
// Two-entry queue between the EMA front end and the ratio back end.
`timescale 1ns / 1ps
module vemaroc_fifo import vemaroc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  vemaroc_job_t wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output vemaroc_job_t rd_data
);
    vemaroc_job_t mem [2];
    logic         wp_reg, rp_reg;
    logic [1:0]   cnt_reg;
    logic         wr_go, rd_go;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr_go    = wr_valid && wr_ready;
    assign rd_go    = rd_valid && rd_ready;
    assign rd_data  = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_go) wp_reg <= ~wp_reg;
            if (rd_go) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_go} - {1'b0, rd_go};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_go) mem[wp_reg] <= wr_data;
    end
endmodule

### rtl/vemaroc_back.sv
// Back end: percent change 100*(E-L)/L with rounding and saturation.
`timescale 1ns / 1ps
module vemaroc_back import vemaroc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         job_valid,
    output logic         job_ready,
    input  vemaroc_job_t job,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // volatility_pct[31:0], bar_index[63:32]
    output logic         m_tlast
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]  state_reg;
    logic        start_reg, neg_reg, zero_reg, last_reg;
    logic [49:0] a_reg;
    logic [48:0] b_reg;
    logic [31:0] idx_reg;
    logic        out_valid_reg, out_last_reg;
    logic [63:0] out_data_reg;

    logic signed [49:0] d;
    logic [73:0]        num, quo;
    logic [48:0]        rem;
    logic               div_done;
    logic [74:0]        q_rnd;
    logic [31:0]        pct;
    logic               load_out;

    assign d   = 50'(job.ema) - 50'(job.lag);
    assign num = (74'(a_reg) << 22) + (74'(a_reg) << 21) + (74'(a_reg) << 18);

    vemaroc_div #(.NUM_W(74), .DEN_W(49)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     (num),
        .den     (b_reg),
        .done    (div_done),
        .quo     (quo),
        .rem     (rem)
    );

    assign q_rnd = 75'(quo) + 75'({rem, 1'b0} >= {1'b0, b_reg});

    always_comb begin
        if (zero_reg) pct = '0;
        else if (neg_reg) pct = (q_rnd >= 75'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q_rnd);
        else pct = (q_rnd > 75'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_rnd[31:0];
    end

    assign job_ready = state_reg == ST_IDLE;
    assign load_out  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        a_reg     <= d[49] ? 50'(-d) : 50'(d);
                        b_reg     <= job.lag[E_W-1] ? 49'(-job.lag) : 49'(job.lag);
                        neg_reg   <= d[49] ^ job.lag[E_W-1];
                        zero_reg  <= job.lag == '0;
                        idx_reg   <= job.idx;
                        last_reg  <= job.last;
                        state_reg <= (job.lag == '0) ? ST_DONE : ST_PREP;
                    end
                end
                ST_PREP: begin
                    start_reg <= 1'b1;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (load_out) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= {idx_reg, pct};
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
endmodule

### rtl/volatility_ema_rate_of_change.sv
// The front end takes a bar only when idle and finishes it first: evaluate while the
// seed sum builds, then evaluate, two-step alpha multiply and ring push, which waits
// on a full queue; the seed bar uses the serial seed divider; an ema_period write
// holds s_tready low while alpha is rederived. The back end takes one job at a time
// (74-bit serial ratio divider), which sets the rate of result bars; 2-beat queue.
// Reset: synchronous, active low; registers back to 10/10, series cleared, alpha
// rederived with s_tready low.
`timescale 1ns / 1ps
module volatility_ema_rate_of_change import vemaroc_pkg::*; #(
    parameter int MAX_LAG = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // high_price[31:0], low_price[63:32]
    input  logic        s_tuser,   // first_bar
    input  logic        s_tlast,   // last_bar
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // volatility_pct[31:0], bar_index[63:32]
    output logic        m_tlast,   // last_output
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_addr,
    input  logic [10:0] cfg_data
);
    logic [10:0]  ema_period_reg;
    logic [5:0]   roc_period_reg;
    logic         ema_wr;
    logic         f_valid, f_ready, b_valid, b_ready;
    vemaroc_job_t f_job, b_job;

    assign cfg_ready = 1'b1;
    assign ema_wr    = cfg_valid && cfg_addr == REG_EMA_PERIOD;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ema_period_reg <= 11'd10;
            roc_period_reg <= 6'd10;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_EMA_PERIOD: ema_period_reg <= cfg_data;
                REG_ROC_PERIOD: roc_period_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    vemaroc_front #(.MAX_LAG(MAX_LAG)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .ema_period (ema_period_reg),
        .roc_period (roc_period_reg),
        .ema_wr     (ema_wr),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    vemaroc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_job)
    );

    vemaroc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );
endmodule

### tb/volatility_ema_rate_of_change_checker.sv
// Checker: predicts volatility results from accepted bars and compares the result beats.
`timescale 1ns / 1ps
module volatility_ema_rate_of_change_checker import vemaroc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_addr,
    input  logic [10:0] cfg_data,
    output int          pending,
    output int          failures
);
    localparam int RING_DEPTH = 32;
    localparam longint EMA_HI = 64'sd281474976710655;
    localparam longint EMA_LO = -64'sd281474976710656;

    typedef struct {
        logic [31:0] pct;
        logic [31:0] idx;
        logic        last;
    } vol_result_t;

    vol_result_t       expected_results[$];
    logic [10:0]       ema_reg;
    logic [5:0]        roc_reg;
    longint unsigned   alpha_q24;
    longint            ema_q16;
    longint            spread_sum;
    logic [31:0]       bar_count;
    longint            lag_hist[RING_DEPTH];
    int unsigned       hist_ptr;

    function automatic longint unsigned ema_len();
        if (ema_reg < 2) return 2;
        if (ema_reg > MAX_EMA_PERIOD) return MAX_EMA_PERIOD;
        return ema_reg;
    endfunction

    function automatic longint unsigned lag_len();
        if (roc_reg < 1) return 1;
        if (roc_reg > RING_DEPTH) return RING_DEPTH;
        return roc_reg;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint clamp49(longint v);
        if (v > EMA_HI) return EMA_HI;
        if (v < EMA_LO) return EMA_LO;
        return v;
    endfunction

    function automatic longint unsigned alpha_step(longint unsigned m);
        longint unsigned hi, lo;
        hi = m >> 24;
        lo = m & 64'hFFFFFF;
        return hi * alpha_q24 + ((lo * alpha_q24 + (64'd1 << 23)) >> 24);
    endfunction

    function automatic logic [31:0] pct_change(longint e, longint l);
        longint unsigned fac[3];
        longint unsigned a, b, q, r, rf;
        longint d;
        bit neg, sat;
        fac = '{100, 256, 256};
        d = e - l;
        neg = (d < 0) != (l < 0);
        a = abs64(d);
        b = abs64(l);
        q = a / b;
        r = a % b;
        sat = q > (64'd1 << 33);
        for (int i = 0; i < 3 && !sat; i++) begin
            rf = r * fac[i];
            q = q * fac[i] + rf / b;
            r = rf % b;
            if (q > (64'd1 << 33)) sat = 1;
        end
        if (!sat && r * 2 >= b) q++;
        if (neg) begin
            if (sat || q >= (64'd1 << 31)) return 32'h8000_0000;
            return 32'(64'd0 - q);
        end
        if (sat || q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return 32'(q);
    endfunction

    task automatic restart_series();
        ema_q16 = 0;
        spread_sum = 0;
        bar_count = 0;
        hist_ptr = 0;
        foreach (lag_hist[i]) lag_hist[i] = 0;
    endtask

    task automatic push_hist(longint v);
        int unsigned p;
        p = hist_ptr < RING_DEPTH ? hist_ptr : 0;
        lag_hist[p] = v;
        hist_ptr = (p + 1 >= lag_len()) ? 0 : p + 1;
    endtask

    task automatic take_bar(logic [31:0] hi_px, logic [31:0] lo_px, logic first, logic last);
        longint spread, diff, lag;
        longint unsigned t, p, r, m, step;
        vol_result_t res;
        if (first) restart_series();
        spread = longint'({32'd0, hi_px}) - longint'({32'd0, lo_px});
        t = bar_count;
        p = ema_len();
        r = lag_len();
        if (t < p - 1) begin
            spread_sum += spread;
        end else if (t == p - 1) begin
            spread_sum += spread;
            m = abs64(spread_sum) << 16;
            m = (m + p / 2) / p;
            ema_q16 = clamp49(spread_sum < 0 ? longint'(0) - longint'(m) : longint'(m));
            push_hist(ema_q16);
        end else begin
            diff = spread * 65536 - ema_q16;
            step = alpha_step(abs64(diff));
            ema_q16 = clamp49(diff < 0 ? ema_q16 - longint'(step) : ema_q16 + longint'(step));
            if (t >= p - 1 + r) begin
                lag = lag_hist[hist_ptr < RING_DEPTH ? hist_ptr : 0];
                res.pct = lag != 0 ? pct_change(ema_q16, lag) : 32'd0;
                res.idx = t[31:0];
                res.last = last;
                expected_results.push_back(res);
            end
            push_hist(ema_q16);
        end
        if (bar_count != 32'hFFFF_FFFF) bar_count++;
    endtask

    always @(posedge aclk) begin
        vol_result_t exp_r;
        if (!aresetn) begin
            ema_reg = 10;
            roc_reg = 10;
            alpha_q24 = ((64'd1 << 25) + 64'd11 / 2) / 64'd11;
            restart_series();
            expected_results.delete();
            failures = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == REG_EMA_PERIOD) begin
                    ema_reg = cfg_data;
                    alpha_q24 = ((64'd1 << 25) + (ema_len() + 1) / 2) / (ema_len() + 1);
                end else begin
                    roc_reg = cfg_data[5:0];
                end
            end
            if (s_tvalid && s_tready)
                take_bar(s_tdata[31:0], s_tdata[63:32], s_tuser, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result beat: pct=%h idx=%0d last=%b",
                                 m_tdata[31:0], m_tdata[63:32], m_tlast);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (exp_r.pct !== m_tdata[31:0] || exp_r.idx !== m_tdata[63:32]
                            || exp_r.last !== m_tlast) begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: exp pct=%h idx=%0d last=%b, got pct=%h idx=%0d last=%b",
                                     exp_r.pct, exp_r.idx, exp_r.last,
                                     m_tdata[31:0], m_tdata[63:32], m_tlast);
                    end
                end
            end
        end
        pending = expected_results.size();
    end
endmodule

### tb/volatility_ema_rate_of_change_test.sv
// Testbench top: drives bars, register writes and result backpressure, and reports.
`timescale 1ns / 1ps
module volatility_ema_rate_of_change_test;
    import vemaroc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // high_price[31:0], low_price[63:32]
    logic        s_tuser;   // first_bar
    logic        s_tlast;   // last_bar
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // volatility_pct[31:0], bar_index[63:32]
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_addr;
    logic [10:0] cfg_data;
    int          pending;
    int          failures;
    bit          hold_req;

    volatility_ema_rate_of_change uut (.*);

    volatility_ema_rate_of_change_checker chk (.*);

    always #2 aclk = ~aclk;

    initial begin
        #4ms;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver backpressure, with one long hold on request
    initial begin
        int k;
        m_tready = 0;
        wait (aresetn);
        forever begin
            if (hold_req) begin
                m_tready <= 0;
                repeat (3000) @(posedge aclk);
                hold_req = 0;
            end
            k = $urandom_range(0, 9);
            if (k < 6) begin
                m_tready <= 1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end else if (k < 9) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 0;
                repeat ($urandom_range(10, 120)) @(posedge aclk);
            end
        end
    end

    task automatic send_bar(logic [31:0] hi_px, logic [31:0] lo_px, logic first, logic last);
        int gap;
        s_tvalid <= 1;
        s_tdata <= {lo_px, hi_px};
        s_tuser <= first;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        gap = $urandom_range(0, 19) < 12 ? 0 :
              ($urandom_range(0, 9) == 0 ? $urandom_range(20, 150) : $urandom_range(1, 4));
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [10:0] val);
        cfg_valid <= 1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic random_bars(int n);
        logic [31:0] hi_px, lo_px;
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            lo_px = $urandom_range(10000, 32'h7FFF_0000);
            if (k < 70) hi_px = lo_px + $urandom_range(0, 5000);
            else if (k < 82) hi_px = lo_px - $urandom_range(1, 5000);
            else if (k < 94) begin
                hi_px = $urandom;
                lo_px = $urandom;
            end else hi_px = lo_px;
            send_bar(hi_px, lo_px, i == 0 || $urandom_range(0, 59) == 0,
                     $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic directed_bars();
        logic [31:0] hi_px[18], lo_px[18];
        logic [17:0] first_f, last_f;
        hi_px = '{0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 1, 1,
                  32'hFFFF_FFFF, 0, 0, 5, 5, 100, 0, 32'hFFFF_FFFF};
        lo_px = '{0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0,
                  0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 5, 7, 0, 32'hFFFF_FFFE};
        first_f = 18'b000000000001000001;
        last_f  = 18'b100100000010010100;
        for (int i = 0; i < 18; i++) send_bar(hi_px[i], lo_px[i], first_f[i], last_f[i]);
    endtask

    initial begin
        aclk = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        s_tlast = 0;
        cfg_valid = 0;
        cfg_addr = REG_EMA_PERIOD;
        cfg_data = '0;
        hold_req = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        random_bars(40);
        wait_drained();
        write_reg(REG_EMA_PERIOD, 2);
        write_reg(REG_ROC_PERIOD, 1);
        directed_bars();
        wait_drained();
        write_reg(REG_EMA_PERIOD, 0);
        write_reg(REG_ROC_PERIOD, 0);
        hold_req = 1;
        random_bars(80);
        wait_drained();
        write_reg(REG_EMA_PERIOD, 3);
        write_reg(REG_ROC_PERIOD, 32);
        random_bars(60);
        wait_drained();
        write_reg(REG_EMA_PERIOD, 24);
        write_reg(REG_ROC_PERIOD, 16);
        random_bars(80);
        wait_drained();
        write_reg(REG_EMA_PERIOD, 2047);
        write_reg(REG_ROC_PERIOD, 63);
        random_bars(30);
        wait_drained();
        write_reg(REG_EMA_PERIOD, 7);
        write_reg(REG_ROC_PERIOD, 4);
        random_bars(80);
        wait_drained();
        write_reg(REG_EMA_PERIOD, 2);
        write_reg(REG_ROC_PERIOD, 1);
        random_bars(60);
        wait_drained();

        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
